[sv/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// No dependencies; spq_cmp, sorted_priority_queue and spq_checker import this package.
`default_nettype none

package spq_pkg;

    // Store geometry
    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // Fixed field widths of the transaction payloads
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Input transaction
    typedef struct packed {
        logic [CMD_W-1:0]              cmd;
        logic signed [VALUE_WIDTH-1:0] key_value;
    } t_req;

    // Result transaction
    typedef struct packed {
        logic [STATUS_W-1:0]           status;
        logic [POS_W-1:0]              position;
        logic signed [VALUE_WIDTH-1:0] head_value;
        logic [COUNT_W-1:0]            entry_count;
        logic                          is_empty;
    } t_rsp;

    // Comparator flags: stored entry versus key
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

`default_nettype wire

[sv/spq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[sv/spq_cmp.sv]
// Shared signed comparator: one stored entry against the search key.
// Depends on spq_pkg.
`default_nettype none

module spq_cmp (
    input  wire logic signed [spq_pkg::VALUE_WIDTH-1:0] i_entry,
    input  wire logic signed [spq_pkg::VALUE_WIDTH-1:0] i_key,
    output spq_pkg::t_cmp                               o_res
);
    import spq_pkg::*;

    // Flag order of entry relative to key
    always_comb begin
        o_res.lt = (i_entry < i_key);
        o_res.eq = (i_entry == i_key);
    end

endmodule

`default_nettype wire

[sv/sorted_priority_queue.sv]
// Sorted priority queue top level: sequencer, entry RAM and shared comparator.
// Depends on spq_pkg, spq_ram and spq_cmp.
//
//   channel   | handshake        | payload | direction
//   ----------+------------------+---------+----------
//   command   | start / busy     | i_req   | in
//   result    | o_done (strobe)  | o_rsp   | out
//
// A command is taken when start is high and busy is low; busy stays high
// through the result strobe. The scan compares one entry at a time, and an
// insert or remove then moves entries one at a time, through the single RAM
// read port and the one comparator; the head is then read and the result
// shown. Synchronous active-low reset empties the queue; no clearing pass is
// needed. The result is shown for one cycle and cannot be stalled.
`default_nettype none

module sorted_priority_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire spq_pkg::t_req i_req,
    output logic               o_done,
    output spq_pkg::t_rsp      o_rsp
);
    import spq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SCAN     = 9'b000000010,
        S_CMP      = 9'b000000100,
        S_SHIFT_RD = 9'b000001000,
        S_SHIFT_WR = 9'b000010000,
        S_CLOSE_RD = 9'b000100000,
        S_CLOSE_WR = 9'b001000000,
        S_HEAD     = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state                  r_state, n_state;
    logic [CMD_W-1:0]        r_cmd, n_cmd;
    logic signed [VALUE_WIDTH-1:0] r_key, n_key;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [CNT_W-1:0]        r_idx, n_idx;
    logic [IDX_W-1:0]        r_pos, n_pos;
    t_status                 r_status, n_status;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [VALUE_WIDTH-1:0]  ram_wdata;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [VALUE_WIDTH-1:0]  ram_rdata;
    t_cmp                    cmp_res;
    logic [CNT_W-1:0]        idx_inc;
    logic [CNT_W-1:0]        idx_dec;

    spq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    spq_cmp u_cmp (
        .i_entry (ram_rdata),
        .i_key   (r_key),
        .o_res   (cmp_res)
    );

    assign idx_inc = r_idx + 1'b1;
    assign idx_dec = r_idx - 1'b1;

    // Sequencer: scan, shift up or close the gap as needed, then read the head
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = r_idx[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_req.cmd;
                    n_key    = i_req.key_value;
                    n_idx    = '0;
                    n_pos    = '0;
                    n_status = ST_NOT_FOUND;
                    case (i_req.cmd) inside
                        CMD_INSERT: begin
                            if (r_cnt == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_HEAD;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_REMOVE, CMD_FIND: n_state = S_SCAN;
                        default:              n_state = S_HEAD;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx == r_cnt) begin
                    // End of list: insert appends, lookups miss
                    if (r_cmd == CMD_INSERT) begin
                        n_pos   = r_idx[IDX_W-1:0];
                        n_idx   = r_cnt;
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_state = S_HEAD;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_idx[IDX_W-1:0];
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                if (r_cmd == CMD_INSERT) begin
                    if (!cmp_res.lt) begin
                        n_pos   = r_idx[IDX_W-1:0];
                        n_idx   = r_cnt;
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = S_SCAN;
                    end
                end else if (cmp_res.eq) begin
                    n_pos    = r_idx[IDX_W-1:0];
                    n_status = ST_DONE;
                    if (r_cmd == CMD_REMOVE) begin
                        n_state = S_CLOSE_RD;
                    end else begin
                        n_state = S_HEAD;
                    end
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_SCAN;
                end
            end
            S_SHIFT_RD: begin
                if (r_idx == CNT_W'(r_pos)) begin
                    // Gap reached: drop the key in
                    ram_we    = 1'b1;
                    ram_waddr = r_pos;
                    ram_wdata = r_key;
                    n_cnt     = r_cnt + 1'b1;
                    n_status  = ST_DONE;
                    n_state   = S_HEAD;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_dec[IDX_W-1:0];
                    n_state   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ram_we  = 1'b1;
                n_idx   = idx_dec;
                n_state = S_SHIFT_RD;
            end
            S_CLOSE_RD: begin
                if (idx_inc >= r_cnt) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_HEAD;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc[IDX_W-1:0];
                    n_state   = S_CLOSE_WR;
                end
            end
            S_CLOSE_WR: begin
                ram_we  = 1'b1;
                n_idx   = idx_inc;
                n_state = S_CLOSE_RD;
            end
            S_HEAD: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                n_state   = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Working registers of the current transaction
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_status <= n_status;
    end

    // Result transaction
    always_comb begin
        busy              = (r_state != S_IDLE);
        o_done            = (r_state == S_DONE);
        o_rsp.status      = r_status;
        o_rsp.position    = POS_W'(r_pos);
        o_rsp.head_value  = (r_cnt != '0) ? ram_rdata : '0;
        o_rsp.entry_count = COUNT_W'(r_cnt);
        o_rsp.is_empty    = (r_cnt == '0);
    end

endmodule

`default_nettype wire

[sv/spq_checker.sv]
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
`default_nettype none

module spq_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire spq_pkg::t_req i_req,
    input wire logic          o_done,
    input wire spq_pkg::t_rsp o_rsp
);
    import spq_pkg::*;

    // An accepted command holds the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // Block is ready again right after a result
    a_ready_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy still high after result");

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.is_empty == (o_rsp.entry_count == '0)))
        else $error("is_empty disagrees with entry_count");

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.entry_count <= COUNT_W'(DEPTH)))
        else $error("entry_count beyond capacity");

    // Full status only when the store is at capacity
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ST_FULL)) |-> (o_rsp.entry_count == COUNT_W'(DEPTH)))
        else $error("full status with free entries");

    // Request payload is not checked; it is only tied off here
    logic unused_req;
    assign unused_req = ^i_req;

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

`default_nettype wire
